/* src/pat_pkg.sv */
// pat_pkg: shared constants, action codes and the sine quarter-wave table builder
// for the point affine transform. No dependencies; every other file imports it.

package pat_pkg;

  // Payload widths of the request and result channels.
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ANGLE_W  = 13;

  // Default number of fraction bits of the fixed-point coordinates.
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Angle resolution and the derived quarter and full turn in angle steps.
  localparam int unsigned ANGLE_STEPS_PER_DEGREE = 16;
  localparam int unsigned QUARTER   = 90 * ANGLE_STEPS_PER_DEGREE;
  localparam int unsigned FULL_TURN = 4 * QUARTER;

  // Table index covers 0..QUARTER inclusive.
  localparam int unsigned IDX_W = $clog2(QUARTER + 1);

  // Table entries hold sin in [0, 1] at up to 24 fraction bits.
  localparam int unsigned SINE_TAB_W = 25;

  // Products of three terms per output coordinate.
  localparam int unsigned TERMS = 3;

  // pi, and the table's angle step in radians.
  localparam real PI_R     = 3.14159265358979323846;
  localparam real STEP_RAD = PI_R / (2.0 * QUARTER);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TRANSLATE = 3'd0,
    ACT_SCALE     = 3'd1,
    ACT_ROT_X     = 3'd2,
    ACT_ROT_Y     = 3'd3,
    ACT_ROT_Z     = 3'd4,
    ACT_SHEAR     = 3'd5
  } action_t;

  typedef logic [SINE_TAB_W-1:0] sine_tab_t [0:QUARTER];

  // Build sin(90 deg * k / QUARTER) rounded to nearest at frac fraction bits.
  // Evaluated at elaboration only.
  function automatic sine_tab_t pat_sine_table(input int unsigned frac);
    sine_tab_t   tab;
    real         scale;
    int          rounded;
    int unsigned k;
    scale = 2.0 ** frac;
    for (k = 0; k <= QUARTER; k++) begin
      rounded = $rtoi($floor($sin(STEP_RAD * k) * scale + 0.5));
      tab[k]  = SINE_TAB_W'(rounded);
    end
    return tab;
  endfunction

endpackage

/* src/pat_in_if.sv */
// pat_in_if: request channel of the point affine transform (valid/ready plus payload).
// Depends on pat_pkg for the payload widths.

interface pat_in_if;
  import pat_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic signed [COORD_W-1:0]  point_z;
  logic signed [COORD_W-1:0]  operand_a;
  logic signed [COORD_W-1:0]  operand_b;
  logic signed [COORD_W-1:0]  operand_c;
  logic signed [COORD_W-1:0]  operand_d;
  logic signed [COORD_W-1:0]  operand_e;
  logic signed [COORD_W-1:0]  operand_f;
  logic [ANGLE_W-1:0]         angle;

  modport source (
    output valid, action, point_x, point_y, point_z,
    output operand_a, operand_b, operand_c, operand_d, operand_e, operand_f, angle,
    input  ready
  );

  modport sink (
    input  valid, action, point_x, point_y, point_z,
    input  operand_a, operand_b, operand_c, operand_d, operand_e, operand_f, angle,
    output ready
  );
endinterface

/* src/pat_out_if.sv */
// pat_out_if: result channel of the point affine transform (valid/ready plus payload).
// Depends on pat_pkg for the payload widths.

interface pat_out_if;
  import pat_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] result_x;
  logic signed [COORD_W-1:0] result_y;
  logic signed [COORD_W-1:0] result_z;
  logic                      saturated;

  modport source (
    output valid, result_x, result_y, result_z, saturated,
    input  ready
  );

  modport sink (
    input  valid, result_x, result_y, result_z, saturated,
    output ready
  );
endinterface

/* src/pat_trig.sv */
// pat_trig: two-stage sine/cosine unit: angle wrap and quadrant split, then
// quarter-wave table lookup with sign fix-up. Depends on pat_pkg.

module pat_trig #(
  parameter int unsigned FRACTION_BITS = pat_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic [1:0]                      en,
  input  logic [pat_pkg::ANGLE_W-1:0]     angle,
  output logic signed [FRACTION_BITS+1:0] sin_val,
  output logic signed [FRACTION_BITS+1:0] cos_val
);
  import pat_pkg::*;

  localparam int unsigned SIN_W = FRACTION_BITS + 2;
  localparam sine_tab_t SINE_TAB = pat_sine_table(FRACTION_BITS);

  localparam logic [ANGLE_W-1:0] FULL_A = ANGLE_W'(FULL_TURN);
  localparam logic [ANGLE_W-1:0] Q1_A   = ANGLE_W'(QUARTER);
  localparam logic [ANGLE_W-1:0] Q2_A   = ANGLE_W'(2 * QUARTER);
  localparam logic [ANGLE_W-1:0] Q3_A   = ANGLE_W'(3 * QUARTER);

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  logic [ANGLE_W-1:0]      wrapped;
  logic [ANGLE_W-1:0]      base;
  logic [ANGLE_W-1:0]      rem;
  quad_t                   quad_nxt;
  quad_t                   quad_r;
  logic [IDX_W-1:0]        idx_up_nxt;
  logic [IDX_W-1:0]        idx_dn_nxt;
  logic [IDX_W-1:0]        idx_up_r;
  logic [IDX_W-1:0]        idx_dn_r;
  logic signed [SIN_W-1:0] up;
  logic signed [SIN_W-1:0] dn;
  logic signed [SIN_W-1:0] sin_nxt;
  logic signed [SIN_W-1:0] cos_nxt;
  logic signed [SIN_W-1:0] sin_r;
  logic signed [SIN_W-1:0] cos_r;

  // Stage 1: wrap one full turn, split into quadrant and offset.
  always_comb begin
    wrapped = (angle >= FULL_A) ? angle - FULL_A : angle;
    if (wrapped >= Q3_A) begin
      quad_nxt = QUAD_IV;
      base     = Q3_A;
    end else if (wrapped >= Q2_A) begin
      quad_nxt = QUAD_III;
      base     = Q2_A;
    end else if (wrapped >= Q1_A) begin
      quad_nxt = QUAD_II;
      base     = Q1_A;
    end else begin
      quad_nxt = QUAD_I;
      base     = '0;
    end
    rem        = wrapped - base;
    idx_up_nxt = rem[IDX_W-1:0];
    idx_dn_nxt = IDX_W'(QUARTER) - rem[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      quad_r   <= quad_nxt;
      idx_up_r <= idx_up_nxt;
      idx_dn_r <= idx_dn_nxt;
    end
  end

  // Stage 2: table lookup, then place by quadrant.
  always_comb begin
    up = $signed({1'b0, SINE_TAB[idx_up_r][FRACTION_BITS:0]});
    dn = $signed({1'b0, SINE_TAB[idx_dn_r][FRACTION_BITS:0]});
    case (quad_r)
      QUAD_I: begin
        sin_nxt = up;
        cos_nxt = dn;
      end
      QUAD_II: begin
        sin_nxt = dn;
        cos_nxt = -up;
      end
      QUAD_III: begin
        sin_nxt = -up;
        cos_nxt = -dn;
      end
      default: begin
        sin_nxt = -dn;
        cos_nxt = up;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

/* src/pat_dot.sv */
// pat_dot: three-stage dot product of one output coordinate: three signed products,
// their sum with the rounding half, then shift and saturate. Depends on pat_pkg.

module pat_dot #(
  parameter int unsigned FRACTION_BITS = pat_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  logic signed [pat_pkg::COORD_W-1:0] mul_a [pat_pkg::TERMS],
  input  logic signed [pat_pkg::COORD_W-1:0] mul_b [pat_pkg::TERMS],
  output logic signed [pat_pkg::COORD_W-1:0] result,
  output logic                              sat
);
  import pat_pkg::*;

  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0]   HALF  = SUM_W'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [COORD_W-1:0] MAX_V = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MIN_V = {1'b1, {(COORD_W - 1){1'b0}}};

  logic signed [PROD_W-1:0]  prod_r [TERMS];
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   shifted;
  logic                      fits;
  logic signed [COORD_W-1:0] result_nxt;
  logic signed [COORD_W-1:0] result_r;
  logic                      sat_nxt;
  logic                      sat_r;

  // Products: one 32x32 multiplier per term.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < TERMS; k++) begin
        prod_r[k] <= PROD_W'(mul_a[k]) * PROD_W'(mul_b[k]);
      end
    end
  end

  // Full-precision sum plus half an output LSB.
  always_comb begin
    sum_nxt = HALF;
    for (int k = 0; k < TERMS; k++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) sum_r <= sum_nxt;
  end

  // Drop the fraction, clip to the coordinate range.
  always_comb begin
    shifted = sum_r >>> FRACTION_BITS;
    fits    = (&shifted[SUM_W-1:COORD_W-1]) || !(|shifted[SUM_W-1:COORD_W-1]);
    sat_nxt = !fits;
    if (fits)              result_nxt = shifted[COORD_W-1:0];
    else if (sum_r[SUM_W-1]) result_nxt = MIN_V;
    else                   result_nxt = MAX_V;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      result_r <= result_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign result = result_r;
  assign sat    = sat_r;

endmodule

/* src/point_affine_transform.sv */
// point_affine_transform: top level of the homogeneous 3-D point transform.
// Depends on pat_pkg, pat_in_if, pat_out_if, pat_trig and pat_dot.
//
// Each request carries one signed Q16.16 point, an action (translate, scale,
// rotate about x, y or z, shear), six coefficients and an angle in sixteenths
// of a degree; each request yields exactly one result: the transformed point,
// rounded half up, saturated to 32 bits, with a flag raised when any coordinate
// was clipped. Actions 6 and 7 return the point unchanged. The block takes one
// request per clock and returns one result per clock while the consumer is
// ready; it has five register stages: angle wrap and quadrant split,
// sine/cosine table lookup, nine parallel 32x32 multiplies, the three-term
// sums, and round/saturate into the output register. Every stage has its own
// valid bit and loads whenever it is empty or its content moves on, so bubbles
// close up and the block keeps taking requests while a finished result waits
// for the consumer; a stall drops and repeats nothing. The sine quarter-wave
// table is a constant ROM built at elaboration; there is no clearing pass and
// no configuration.

module point_affine_transform #(
  parameter int unsigned FRACTION_BITS = pat_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pat_in_if.sink    in_chan,
  pat_out_if.source out_chan
);
  import pat_pkg::*;

  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned NUM_COORDS = 3;
  localparam int unsigned NUM_OPS    = 6;
  localparam int unsigned SIN_W      = FRACTION_BITS + 2;

  // Coordinate and operand slots.
  localparam int unsigned PX = 0;
  localparam int unsigned PY = 1;
  localparam int unsigned PZ = 2;
  localparam int unsigned OP_A = 0;
  localparam int unsigned OP_B = 1;
  localparam int unsigned OP_C = 2;
  localparam int unsigned OP_D = 3;
  localparam int unsigned OP_E = 4;
  localparam int unsigned OP_F = 5;

  localparam logic signed [COORD_W-1:0] ONE   = COORD_W'(1) <<< FRACTION_BITS;
  localparam logic signed [COORD_W-1:0] MAX_V = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MIN_V = {1'b1, {(COORD_W - 1){1'b0}}};

  // Pipeline control: one valid bit per stage, ready ripples back from the output.
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES-1:0] rdy;

  // Request payload carried through stages 1 and 2.
  action_t                   act_s1_r;
  action_t                   act_s2_r;
  logic signed [COORD_W-1:0] pt_s1_r [NUM_COORDS];
  logic signed [COORD_W-1:0] pt_s2_r [NUM_COORDS];
  logic signed [COORD_W-1:0] op_s1_r [NUM_OPS];
  logic signed [COORD_W-1:0] op_s2_r [NUM_OPS];

  // Trig results, valid alongside stage 2.
  logic signed [SIN_W-1:0]   sin_s2;
  logic signed [SIN_W-1:0]   cos_s2;
  logic signed [COORD_W-1:0] sin_w;
  logic signed [COORD_W-1:0] cos_w;
  logic signed [COORD_W-1:0] nsin_w;

  // Multiplier operands per output coordinate, and the finished coordinates.
  logic signed [COORD_W-1:0] mul_a [NUM_COORDS][TERMS];
  logic signed [COORD_W-1:0] mul_b [NUM_COORDS][TERMS];
  logic signed [COORD_W-1:0] res   [NUM_COORDS];
  logic [NUM_COORDS-1:0]     sat;

  logic in_acc;
  logic out_acc;

  // A stage may load when it is empty or its content moves on this edge.
  always_comb begin
    rdy[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_chan.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // Advance valid bits; a stage that cannot load holds.
  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) v_nxt[0] = in_chan.valid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Hold off requests while reset is applied.
  assign in_chan.ready = rdy[0] && rst_n;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_acc       = out_chan.valid && out_chan.ready;

  // Stage 1: capture the request.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      act_s1_r      <= action_t'(in_chan.action);
      pt_s1_r[PX]   <= in_chan.point_x;
      pt_s1_r[PY]   <= in_chan.point_y;
      pt_s1_r[PZ]   <= in_chan.point_z;
      op_s1_r[OP_A] <= in_chan.operand_a;
      op_s1_r[OP_B] <= in_chan.operand_b;
      op_s1_r[OP_C] <= in_chan.operand_c;
      op_s1_r[OP_D] <= in_chan.operand_d;
      op_s1_r[OP_E] <= in_chan.operand_e;
      op_s1_r[OP_F] <= in_chan.operand_f;
    end
  end

  // Stage 2: carry the payload alongside the table lookup.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      act_s2_r <= act_s1_r;
      pt_s2_r  <= pt_s1_r;
      op_s2_r  <= op_s1_r;
    end
  end

  // Angle wrap and quadrant split load with stage 1, lookup with stage 2.
  pat_trig #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_trig (
    .clk    (clk),
    .en     (rdy[1:0]),
    .angle  (in_chan.angle),
    .sin_val(sin_s2),
    .cos_val(cos_s2)
  );

  assign sin_w  = COORD_W'(sin_s2);
  assign cos_w  = COORD_W'(cos_s2);
  assign nsin_w = -sin_w;

  // Build the matrix column of each output coordinate. Every coordinate starts as
  // the identity term (own coordinate times one); unused terms multiply zeros.
  always_comb begin
    for (int j = 0; j < NUM_COORDS; j++) begin
      for (int k = 0; k < TERMS; k++) begin
        mul_a[j][k] = '0;
        mul_b[j][k] = '0;
      end
      mul_a[j][0] = pt_s2_r[j];
      mul_b[j][0] = ONE;
    end
    case (act_s2_r)
      ACT_TRANSLATE: begin
        for (int j = 0; j < NUM_COORDS; j++) begin
          mul_a[j][1] = ONE;
          mul_b[j][1] = op_s2_r[j];
        end
      end
      ACT_SCALE: begin
        for (int j = 0; j < NUM_COORDS; j++) begin
          mul_b[j][0] = op_s2_r[j];
        end
      end
      ACT_ROT_X: begin
        mul_b[PY][0] = cos_w;
        mul_a[PY][1] = pt_s2_r[PZ];
        mul_b[PY][1] = nsin_w;
        mul_a[PZ][0] = pt_s2_r[PY];
        mul_b[PZ][0] = sin_w;
        mul_a[PZ][1] = pt_s2_r[PZ];
        mul_b[PZ][1] = cos_w;
      end
      ACT_ROT_Y: begin
        mul_b[PX][0] = cos_w;
        mul_a[PX][1] = pt_s2_r[PZ];
        mul_b[PX][1] = sin_w;
        mul_a[PZ][0] = pt_s2_r[PX];
        mul_b[PZ][0] = nsin_w;
        mul_a[PZ][1] = pt_s2_r[PZ];
        mul_b[PZ][1] = cos_w;
      end
      ACT_ROT_Z: begin
        mul_b[PX][0] = cos_w;
        mul_a[PX][1] = pt_s2_r[PY];
        mul_b[PX][1] = nsin_w;
        mul_a[PY][0] = pt_s2_r[PX];
        mul_b[PY][0] = sin_w;
        mul_a[PY][1] = pt_s2_r[PY];
        mul_b[PY][1] = cos_w;
      end
      ACT_SHEAR: begin
        // x' = x + y*c + z*e
        mul_a[PX][1] = pt_s2_r[PY];
        mul_b[PX][1] = op_s2_r[OP_C];
        mul_a[PX][2] = pt_s2_r[PZ];
        mul_b[PX][2] = op_s2_r[OP_E];
        // y' = x*a + y + z*f
        mul_a[PY][0] = pt_s2_r[PX];
        mul_b[PY][0] = op_s2_r[OP_A];
        mul_a[PY][1] = pt_s2_r[PY];
        mul_b[PY][1] = ONE;
        mul_a[PY][2] = pt_s2_r[PZ];
        mul_b[PY][2] = op_s2_r[OP_F];
        // z' = x*b + y*d + z
        mul_a[PZ][0] = pt_s2_r[PX];
        mul_b[PZ][0] = op_s2_r[OP_B];
        mul_a[PZ][1] = pt_s2_r[PY];
        mul_b[PZ][1] = op_s2_r[OP_D];
        mul_a[PZ][2] = pt_s2_r[PZ];
        mul_b[PZ][2] = ONE;
      end
      default: begin
        // Undefined actions: pass the point through via the identity terms.
      end
    endcase
  end

  // Stages 3 to 5: products, sums, round and saturate, one unit per coordinate.
  for (genvar j = 0; j < NUM_COORDS; j++) begin : g_dot
    pat_dot #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_dot (
      .clk   (clk),
      .en    (rdy[4:2]),
      .mul_a (mul_a[j]),
      .mul_b (mul_b[j]),
      .result(res[j]),
      .sat   (sat[j])
    );
  end

  assign out_chan.valid     = v_r[NUM_STAGES-1];
  assign out_chan.result_x  = res[PX];
  assign out_chan.result_y  = res[PY];
  assign out_chan.result_z  = res[PZ];
  assign out_chan.saturated = |sat;

  // Occupancy tracks requests in minus results out: nothing lost or doubled.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_acc) |=> ($countones(v_r) == $past($countones(v_r)) + 1))
    else $error("pipeline occupancy did not grow on a lone request");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && out_acc) |=> ($countones(v_r) + 1 == $past($countones(v_r))))
    else $error("pipeline occupancy did not shrink on a lone result");

  a_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc == out_acc) |=> ($countones(v_r) == $past($countones(v_r))))
    else $error("pipeline occupancy changed with balanced traffic");

  // A clipped result must show a clipped coordinate.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.saturated) |->
      (out_chan.result_x == MAX_V || out_chan.result_x == MIN_V ||
       out_chan.result_y == MAX_V || out_chan.result_y == MIN_V ||
       out_chan.result_z == MAX_V || out_chan.result_z == MIN_V))
    else $error("saturation flag without a clipped coordinate");

endmodule

/* tb/point_affine_transform_test.sv */
// Self-checking testbench for point_affine_transform: random bursts of transform requests
// are checked against a predictor of the matrix arithmetic, under random result stalls.
// Depends on pat_pkg, pat_in_if, pat_out_if and the point_affine_transform RTL.
`timescale 1ns / 100ps

module point_affine_transform_test;
  import pat_pkg::*;

  localparam int unsigned FRAC        = FRACTION_BITS_DEF;
  localparam int unsigned QTR         = QUARTER;
  localparam int unsigned RANDOM_REQS = 1750;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 12;   // five pipeline stages, with margin

  // Actions outside the defined set; the block must pass the point straight through.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic signed [COORD_W-1:0] FX_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] FX_MIN  = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] FX_ONE  = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] FX_MONE = 32'shFFFF_0000;
  localparam logic signed [COORD_W-1:0] FX_HALF = 32'sh0000_8000;

  // Wide accumulator constants for the round-and-clip step.
  localparam logic signed [79:0] UNIT     = 80'sd1 <<< FRAC;
  localparam logic signed [79:0] HALF_LSB = 80'sd1 <<< (FRAC - 1);
  localparam logic signed [79:0] SAT_MAX  = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] SAT_MIN  = -SAT_MAX - 80'sd1;

  typedef struct {
    logic [ACTION_W-1:0]       action;
    logic signed [COORD_W-1:0] px, py, pz;
    logic signed [COORD_W-1:0] a, b, c, d, e, f;
    logic [ANGLE_W-1:0]        angle;
  } request_t;

  typedef struct {
    logic signed [COORD_W-1:0] x, y, z;
    logic                      clipped;
  } point_t;

  logic clk;
  logic rst_n;

  pat_in_if  req_if ();
  pat_out_if res_if ();

  point_affine_transform DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  // Requests waiting to be offered, and transformed points still owed by the block.
  request_t    pending_requests [$];
  point_t      expected_points [$];
  int unsigned drain_marks [$];
  int          sine_q16 [0:QTR];

  int unsigned total_requests;
  int unsigned accepted_count;
  int unsigned presented_count;
  int unsigned error_count;
  int unsigned cycle_count;
  bit          req_fired;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned sink_mode;
  int unsigned sink_tick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sum three full-precision products, round half up, and clip to the coordinate range.
  function automatic logic signed [COORD_W-1:0] round_clip(
    input logic signed [79:0] a0, m0, a1, m1, a2, m2, inout bit clip);
    logic signed [79:0] acc;
    acc = a0 * m0 + a1 * m1 + a2 * m2 + HALF_LSB;
    acc = acc >>> FRAC;
    if (acc > SAT_MAX) begin
      clip = 1'b1;
      return FX_MAX;
    end
    if (acc < SAT_MIN) begin
      clip = 1'b1;
      return FX_MIN;
    end
    return acc[COORD_W-1:0];
  endfunction

  // Expected transformed point for one request.
  function automatic point_t transform_point(input request_t r);
    point_t             p;
    logic signed [79:0] s, c, x, y, z;
    int unsigned        wrapped, quad, rem;
    bit                 clip;
    wrapped = r.angle % FULL_TURN;
    quad    = wrapped / QTR;
    rem     = wrapped % QTR;
    // fold the quarter-wave table out to the full circle
    case (quad)
      0:       begin s =  sine_q16[rem];       c =  sine_q16[QTR - rem]; end
      1:       begin s =  sine_q16[QTR - rem]; c = -sine_q16[rem];       end
      2:       begin s = -sine_q16[rem];       c = -sine_q16[QTR - rem]; end
      default: begin s = -sine_q16[QTR - rem]; c =  sine_q16[rem];       end
    endcase
    x    = r.px;
    y    = r.py;
    z    = r.pz;
    clip = 1'b0;
    p.x  = r.px;
    p.y  = r.py;
    p.z  = r.pz;
    case (r.action)
      ACT_TRANSLATE: begin
        p.x = round_clip(x, UNIT, UNIT, r.a, 0, 0, clip);
        p.y = round_clip(y, UNIT, UNIT, r.b, 0, 0, clip);
        p.z = round_clip(z, UNIT, UNIT, r.c, 0, 0, clip);
      end
      ACT_SCALE: begin
        p.x = round_clip(x, r.a, 0, 0, 0, 0, clip);
        p.y = round_clip(y, r.b, 0, 0, 0, 0, clip);
        p.z = round_clip(z, r.c, 0, 0, 0, 0, clip);
      end
      ACT_ROT_X: begin
        p.x = round_clip(x, UNIT, 0, 0, 0, 0, clip);
        p.y = round_clip(y, c, z, -s, 0, 0, clip);
        p.z = round_clip(y, s, z, c, 0, 0, clip);
      end
      ACT_ROT_Y: begin
        p.x = round_clip(x, c, z, s, 0, 0, clip);
        p.y = round_clip(y, UNIT, 0, 0, 0, 0, clip);
        p.z = round_clip(x, -s, z, c, 0, 0, clip);
      end
      ACT_ROT_Z: begin
        p.x = round_clip(x, c, y, -s, 0, 0, clip);
        p.y = round_clip(x, s, y, c, 0, 0, clip);
        p.z = round_clip(z, UNIT, 0, 0, 0, 0, clip);
      end
      ACT_SHEAR: begin
        p.x = round_clip(x, UNIT, y, r.c, z, r.e, clip);
        p.y = round_clip(x, r.a, y, UNIT, z, r.f, clip);
        p.z = round_clip(x, r.b, y, r.d, z, UNIT, clip);
      end
      default: ;  // spare actions: point passes through, no clipping
    endcase
    p.clipped = clip;
    return p;
  endfunction

  function automatic request_t make_request(
    input logic [ACTION_W-1:0] act, input logic signed [COORD_W-1:0] x, y, z,
    input logic signed [COORD_W-1:0] a, b, c, d, e, f, input logic [ANGLE_W-1:0] ang);
    request_t r;
    r.action = act;
    r.px = x; r.py = y; r.pz = z;
    r.a = a; r.b = b; r.c = c; r.d = d; r.e = e; r.f = f;
    r.angle = ang;
    return r;
  endfunction

  // Mix of full-range, small, whole-unit, extreme and mid-sized Q16.16 values.
  function automatic logic signed [COORD_W-1:0] random_fixed();
    logic signed [COORD_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3, 4:    v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      5:       v = ($urandom_range(0, 8) - 4) * 32'h0001_0000;
      6: begin
        case ($urandom_range(0, 4))
          0:       v = FX_MAX;
          1:       v = FX_MIN;
          2:       v = 32'sd0;
          3:       v = -32'sd1;
          default: v = FX_ONE;
        endcase
      end
      default: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r = make_request(ACT_TRANSLATE, random_fixed(), random_fixed(), random_fixed(),
                     random_fixed(), random_fixed(), random_fixed(), random_fixed(),
                     random_fixed(), random_fixed(), 13'd0);
    if ($urandom_range(0, 49) == 0)
      r.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    else
      r.action = ACTION_W'($urandom_range(int'(ACT_TRANSLATE), int'(ACT_SHEAR)));
    case ($urandom_range(0, 19))
      0:       r.angle = ANGLE_W'($urandom_range(0, 3) * QTR);      // exact quadrant edges
      1:       r.angle = ANGLE_W'($urandom_range(FULL_TURN, 8191)); // needs wrapping
      default: r.angle = ANGLE_W'($urandom_range(0, FULL_TURN - 1));
    endcase
    return r;
  endfunction

  task automatic report_field(input string name, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
      error_count++;
    end
  endtask

  // Stimulus: build the table, queue directed then random requests, run and judge.
  initial begin
    int unsigned k;
    int unsigned directed_total;
    real         angle_rad;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = '0;
    req_if.point_x = '0; req_if.point_y = '0; req_if.point_z = '0;
    req_if.operand_a = '0; req_if.operand_b = '0; req_if.operand_c = '0;
    req_if.operand_d = '0; req_if.operand_e = '0; req_if.operand_f = '0;
    req_if.angle = '0;
    res_if.ready = 1'b0;
    accepted_count = 0;
    presented_count = 0;
    error_count = 0;
    burst_left = 0;
    gap_left = 0;
    sink_mode = 0;
    sink_tick = 0;

    // Quarter-wave sine, rounded to nearest at the fraction width.
    for (k = 0; k <= QTR; k++) begin
      angle_rad   = 3.14159265358979323846 * k / (2.0 * QTR);
      sine_q16[k] = $rtoi($floor($sin(angle_rad) * (2.0 ** FRAC) + 0.5));
    end

    // Directed: field extremes, every action, rounding ties, wrapped angles, spares.
    pending_requests.push_back(make_request(ACT_TRANSLATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(ACT_TRANSLATE, FX_MAX, FX_MIN, FX_ONE,
                               FX_MAX, FX_MIN, FX_MONE, FX_MAX, FX_MIN, FX_MAX, 13'h1FFF));
    pending_requests.push_back(make_request(ACT_TRANSLATE, FX_MIN, FX_MAX, -1,
                               FX_MIN, FX_MAX, 1, FX_MIN, FX_MAX, FX_MIN, 0));
    pending_requests.push_back(make_request(ACT_SCALE, FX_MAX, FX_MIN, 1,
                               FX_ONE, FX_ONE, FX_HALF, 0, 0, 0, 0));
    pending_requests.push_back(make_request(ACT_SCALE, 1, -1, 3,
                               FX_HALF, FX_HALF, FX_HALF, 0, 0, 0, 0));
    pending_requests.push_back(make_request(ACT_SCALE, FX_MAX, FX_MIN, FX_MIN,
                               FX_MAX, FX_MIN, FX_MONE, 0, 0, 0, 0));
    pending_requests.push_back(make_request(ACT_ROT_X, FX_ONE, FX_ONE, FX_MONE,
                               0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(ACT_ROT_X, FX_ONE, FX_ONE, FX_MONE,
                               0, 0, 0, 0, 0, 0, ANGLE_W'(QTR)));
    pending_requests.push_back(make_request(ACT_ROT_X, FX_MAX, FX_MAX, FX_MIN,
                               0, 0, 0, 0, 0, 0, ANGLE_W'(QTR / 2)));
    pending_requests.push_back(make_request(ACT_ROT_Y, FX_ONE, 5, FX_ONE,
                               0, 0, 0, 0, 0, 0, ANGLE_W'(2 * QTR)));
    pending_requests.push_back(make_request(ACT_ROT_Y, FX_MIN, FX_MAX, FX_MIN,
                               0, 0, 0, 0, 0, 0, ANGLE_W'(QTR / 2)));
    pending_requests.push_back(make_request(ACT_ROT_Z, FX_ONE, FX_MONE, 7,
                               0, 0, 0, 0, 0, 0, ANGLE_W'(3 * QTR)));
    pending_requests.push_back(make_request(ACT_ROT_Z, FX_ONE, FX_ONE, 0,
                               0, 0, 0, 0, 0, 0, ANGLE_W'(FULL_TURN - 1)));
    pending_requests.push_back(make_request(ACT_ROT_Z, FX_ONE, FX_ONE, 0,
                               0, 0, 0, 0, 0, 0, ANGLE_W'(FULL_TURN)));
    pending_requests.push_back(make_request(ACT_ROT_X, 0, FX_ONE, FX_ONE,
                               0, 0, 0, 0, 0, 0, 13'h1FFF));
    pending_requests.push_back(make_request(ACT_SHEAR, FX_ONE, FX_ONE, FX_ONE,
                               FX_HALF, FX_MONE, FX_ONE, FX_HALF, -FX_HALF, 0, 0));
    pending_requests.push_back(make_request(ACT_SHEAR, FX_MAX, FX_MAX, FX_MAX,
                               FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 0));
    pending_requests.push_back(make_request(ACT_SHEAR, FX_MIN, FX_MAX, FX_MIN,
                               FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, 0));
    pending_requests.push_back(make_request(ACT_SPARE_LO, FX_MAX, FX_MIN, 1,
                               FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX,
                               ANGLE_W'(QTR)));
    pending_requests.push_back(make_request(ACT_SPARE_HI, FX_MIN, FX_MAX, -1,
                               FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 13'h1FFF));
    directed_total = pending_requests.size();

    for (k = 0; k < RANDOM_REQS; k++)
      pending_requests.push_back(random_request());
    total_requests = pending_requests.size();

    // Hold the sender back until the block has emptied, after the directed part and midway.
    drain_marks.push_back(directed_total);
    drain_marks.push_back(directed_total + RANDOM_REQS / 2);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_requests) @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("point_affine_transform regression: pass");
    else
      $display("point_affine_transform regression: fail");
    $finish;
  end

  // Request driver: hold an offered request until taken, otherwise advance in bursts and gaps.
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_fired) begin
      // hold: the offered request has not been taken yet
    end else if (drain_marks.size() != 0 && presented_count == drain_marks[0]) begin
      req_if.valid <= 1'b0;
      if (expected_points.size() == 0)
        void'(drain_marks.pop_front());
    end else if (gap_left != 0) begin
      req_if.valid <= 1'b0;
      gap_left--;
    end else if (pending_requests.size() != 0) begin
      r = pending_requests.pop_front();
      req_if.valid     <= 1'b1;
      req_if.action    <= r.action;
      req_if.point_x   <= r.px;
      req_if.point_y   <= r.py;
      req_if.point_z   <= r.pz;
      req_if.operand_a <= r.a;
      req_if.operand_b <= r.b;
      req_if.operand_c <= r.c;
      req_if.operand_d <= r.d;
      req_if.operand_e <= r.e;
      req_if.operand_f <= r.f;
      req_if.angle     <= r.angle;
      presented_count++;
      if (burst_left > 1) begin
        burst_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        // long back-to-back stretch
        burst_left = $urandom_range(40, 200);
        gap_left   = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap_left   = $urandom_range(0, 6);
      end
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Result consumer: stall on a pattern that is redrawn at random from time to time.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      sink_tick++;
      if (sink_tick % 48 == 0)
        sink_mode = $urandom_range(0, 3);
      case (sink_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 3) != 0);
        2:       res_if.ready <= (sink_tick % 3 != 0);
        default: res_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check each returned point against the oldest prediction, then record any new request.
  always @(posedge clk) begin
    point_t   want;
    request_t taken;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_points.size() == 0) begin
        $error("result with no request outstanding: x %0d y %0d z %0d",
               res_if.result_x, res_if.result_y, res_if.result_z);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        report_field("result_x", want.x, res_if.result_x);
        report_field("result_y", want.y, res_if.result_y);
        report_field("result_z", want.z, res_if.result_z);
        report_field("saturated", {31'd0, want.clipped}, {31'd0, res_if.saturated});
      end
    end
    if (rst_n && req_if.valid && req_if.ready) begin
      taken = make_request(req_if.action, req_if.point_x, req_if.point_y, req_if.point_z,
                           req_if.operand_a, req_if.operand_b, req_if.operand_c,
                           req_if.operand_d, req_if.operand_e, req_if.operand_f,
                           req_if.angle);
      expected_points.push_back(transform_point(taken));
      accepted_count++;
    end
    req_fired <= rst_n && req_if.valid && req_if.ready;
  end

  // Watchdog: drop the run if it overstays the cycle budget.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("point_affine_transform regression: fail");
      $finish;
    end
  end

endmodule
